// ----- rtl/lz77se_pkg.sv -----
// Package: shared types and constants of the LZ77 sequence executor.
package lz77se_pkg;

  localparam int unsigned OutDepthDef  = 65536;
  localparam int unsigned LitDepthDef  = 65536;
  localparam int unsigned DictDepthDef = 65536;

  localparam logic [16:0] CapReset  = 17'd65536;
  localparam logic [16:0] DlenReset = 17'd0;

  typedef enum logic [2:0] {
    ACT_LIT   = 3'd0,
    ACT_DICT  = 3'd1,
    ACT_EXEC  = 3'd2,
    ACT_READ  = 3'd3,
    ACT_CLEAR = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SMALL   = 2'd1,
    ST_CORRUPT = 2'd2
  } status_t;

  typedef enum logic {
    CFG_CAP  = 1'b0,
    CFG_DLEN = 1'b1
  } cfg_idx_t;

  // Classified command handed from front to back.
  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  data_byte;
    logic [15:0] address;
    logic [16:0] lit_length;
    logic [16:0] match_length;
    logic [17:0] offset;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LRD,
    BK_CHK,
    BK_DICT,
    BK_COPY,
    BK_ORD,
    BK_DONE
  } bk_state_t;

endpackage

// ----- rtl/lz77se_front.sv -----
// Front end: accepts input beats and queues them as commands.
module lz77se_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic [7:0]         in_data_byte,
  input  logic [15:0]        in_address,
  input  logic [16:0]        in_lit_length,
  input  logic [16:0]        in_match_length,
  input  logic [17:0]        in_offset,
  output logic               q_valid,
  output lz77se_pkg::cmd_t   q_cmd,
  input  logic               q_pop
);

  lz77se_pkg::cmd_t q_r [2];
  logic             wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{action: in_action, data_byte: in_data_byte, address: in_address,
                     lit_length: in_lit_length, match_length: in_match_length,
                     offset: in_offset};
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !q_pop) |=> in_stall) else $error("full queue not stalled");

endmodule

// ----- rtl/lz77se_back.sv -----
// Back end: memories, sequence execution and the result register.
module lz77se_back #(
  parameter int unsigned OUT_DEPTH  = lz77se_pkg::OutDepthDef,
  parameter int unsigned LIT_DEPTH  = lz77se_pkg::LitDepthDef,
  parameter int unsigned DICT_DEPTH = lz77se_pkg::DictDepthDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  lz77se_pkg::cmd_t q_cmd,
  output logic             q_pop,
  input  logic [16:0]      cap_cfg,
  input  logic [16:0]      dlen_cfg,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_status,
  output logic [17:0]      out_seq_length,
  output logic [7:0]       out_read_data
);

  localparam int OAW = $clog2(OUT_DEPTH);
  localparam int LAW = $clog2(LIT_DEPTH);
  localparam int DAW = $clog2(DICT_DEPTH);
  localparam int PW  = 26;  // wide enough for all position sums

  logic [7:0] omem [OUT_DEPTH];
  logic [7:0] lmem [LIT_DEPTH];
  logic [7:0] dmem [DICT_DEPTH];

  lz77se_pkg::bk_state_t st_r, st_nxt;
  lz77se_pkg::cmd_t      cmd_r;

  logic [PW-1:0] wpos_r, lrp_r, lcnt_r;
  logic [PW-1:0] cnt_r;            // bytes remaining in current copy phase
  logic [PW-1:0] dst_r, src_r;     // output dst, source index (lit/dict/out)
  logic [PW-1:0] mrem_r;           // match bytes left after dict phase
  logic [PW-1:0] lit_end_r, mend_r;
  logic          rd_pend_r;        // a read issued last cycle
  logic [7:0]    rdat_r;

  logic [1:0]    wstat_r;
  logic [17:0]   wseq_r;
  logic [7:0]    wrd_r;

  logic          ov_r;
  logic [1:0]    ostat_r;
  logic [17:0]   oseq_r;
  logic [7:0]    ord_r;

  logic [PW-1:0] cap, dlen, back;
  logic [PW-1:0] addr_w, lit_end_c, mend_c;
  logic          ovf, ovr, off_bad, off_dict, copy_idle;
  logic          om_we, lm_we, dm_we;

  assign cap  = ({9'd0, cap_cfg} > PW'(OUT_DEPTH)) ? PW'(OUT_DEPTH) : {9'd0, cap_cfg};
  assign dlen = ({9'd0, dlen_cfg} > PW'(DICT_DEPTH)) ? PW'(DICT_DEPTH) : {9'd0, dlen_cfg};
  assign back = {8'd0, cmd_r.offset} - lit_end_r;

  assign addr_w    = {10'd0, cmd_r.address};
  assign lit_end_c = wpos_r + {9'd0, cmd_r.lit_length};
  assign mend_c    = lit_end_c + {9'd0, cmd_r.match_length};
  assign ovf       = mend_c > cap;
  assign ovr       = (lrp_r + {9'd0, cmd_r.lit_length}) > lcnt_r;
  assign off_bad   = (cmd_r.offset == '0) || ({8'd0, cmd_r.offset} > lit_end_r + dlen);
  assign off_dict  = {8'd0, cmd_r.offset} > lit_end_r;
  assign copy_idle = (cnt_r == '0) && !rd_pend_r;

  assign out_valid      = ov_r;
  assign out_status     = ostat_r;
  assign out_seq_length = oseq_r;
  assign out_read_data  = ord_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      lz77se_pkg::BK_IDLE: if (q_valid) st_nxt = lz77se_pkg::BK_LRD;
      lz77se_pkg::BK_LRD: begin
        st_nxt = lz77se_pkg::BK_DONE;
        if (cmd_r.action == lz77se_pkg::ACT_EXEC && !ovf && !ovr) begin
          st_nxt = lz77se_pkg::BK_COPY;
        end else if (cmd_r.action == lz77se_pkg::ACT_READ && addr_w < PW'(OUT_DEPTH)) begin
          st_nxt = lz77se_pkg::BK_ORD;
        end
      end
      lz77se_pkg::BK_COPY: begin
        if (copy_idle) begin
          if (mrem_r == '1) st_nxt = lz77se_pkg::BK_CHK;
          else if (mrem_r == '0) st_nxt = lz77se_pkg::BK_DONE;
        end
      end
      lz77se_pkg::BK_CHK: begin
        if (off_bad) st_nxt = lz77se_pkg::BK_DONE;
        else if (off_dict) st_nxt = lz77se_pkg::BK_DICT;
        else st_nxt = lz77se_pkg::BK_COPY;
      end
      lz77se_pkg::BK_DICT: if (copy_idle) st_nxt = lz77se_pkg::BK_COPY;
      lz77se_pkg::BK_ORD:  if (rd_pend_r) st_nxt = lz77se_pkg::BK_DONE;
      lz77se_pkg::BK_DONE: if (!ov_r || !out_stall) st_nxt = lz77se_pkg::BK_IDLE;
      default:             st_nxt = lz77se_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (st_r == lz77se_pkg::BK_IDLE) && q_valid;
    om_we = rd_pend_r && (st_r == lz77se_pkg::BK_COPY || st_r == lz77se_pkg::BK_DICT);
    lm_we = (st_r == lz77se_pkg::BK_LRD) && (cmd_r.action == lz77se_pkg::ACT_LIT)
            && (lcnt_r < PW'(LIT_DEPTH));
    dm_we = (st_r == lz77se_pkg::BK_LRD) && (cmd_r.action == lz77se_pkg::ACT_DICT)
            && (addr_w < PW'(DICT_DEPTH));
  end

  // Sequencer: during a copy one memory read is issued per cycle, and its byte is written in the cycle after.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= lz77se_pkg::BK_IDLE;
      wpos_r    <= '0;
      lrp_r     <= '0;
      lcnt_r    <= '0;
      ov_r      <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == lz77se_pkg::BK_DONE && (!ov_r || !out_stall)) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      rd_pend_r <= 1'b0;
      unique case (st_r)
        lz77se_pkg::BK_IDLE: begin
          if (q_valid) cmd_r <= q_cmd;
        end
        lz77se_pkg::BK_LRD: begin
          wstat_r <= lz77se_pkg::ST_OK;
          wseq_r  <= '0;
          wrd_r   <= '0;
          unique case (cmd_r.action)
            lz77se_pkg::ACT_LIT: begin
              if (lcnt_r < PW'(LIT_DEPTH)) begin
                lcnt_r <= lcnt_r + 1'b1;
              end
            end
            lz77se_pkg::ACT_CLEAR: begin
              lcnt_r <= '0;
              lrp_r  <= '0;
            end
            lz77se_pkg::ACT_EXEC: begin
              lit_end_r <= lit_end_c;
              mend_r    <= mend_c;
              if (ovf) begin
                wstat_r <= lz77se_pkg::ST_SMALL;
              end else if (ovr) begin
                wstat_r <= lz77se_pkg::ST_CORRUPT;
              end else begin
                cnt_r  <= {9'd0, cmd_r.lit_length};
                src_r  <= lrp_r;
                dst_r  <= wpos_r;
                mrem_r <= '1;  // marks literal phase
              end
            end
            default: ;
          endcase
        end
        lz77se_pkg::BK_COPY: begin
          // phase: literals (mrem all ones), then match bytes copied from output memory
          if (rd_pend_r) dst_r <= dst_r + 1'b1;
          if (cnt_r != '0) begin
            cnt_r     <= cnt_r - 1'b1;
            src_r     <= src_r + 1'b1;
            rd_pend_r <= 1'b1;
          end else if (!rd_pend_r) begin
            if (mrem_r == '1) begin
              lrp_r <= lrp_r + {9'd0, cmd_r.lit_length};
            end else if (mrem_r != '0) begin
              cnt_r  <= mrem_r;
              mrem_r <= '0;
              src_r  <= '0;
            end else begin
              wpos_r <= mend_r;
              wseq_r <= {1'b0, cmd_r.lit_length} + {1'b0, cmd_r.match_length};
            end
          end
        end
        lz77se_pkg::BK_CHK: begin
          if (off_bad) begin
            wstat_r <= lz77se_pkg::ST_CORRUPT;
          end else if (off_dict) begin
            cnt_r  <= ({9'd0, cmd_r.match_length} < back) ? {9'd0, cmd_r.match_length} : back;
            mrem_r <= ({9'd0, cmd_r.match_length} < back) ? '0
                      : {9'd0, cmd_r.match_length} - back;
            src_r  <= PW'(DICT_DEPTH) - back;
          end else begin
            cnt_r  <= {9'd0, cmd_r.match_length};
            mrem_r <= '0;
            src_r  <= lit_end_r - {8'd0, cmd_r.offset};
          end
        end
        lz77se_pkg::BK_DICT: begin
          if (rd_pend_r) dst_r <= dst_r + 1'b1;
          if (cnt_r != '0) begin
            cnt_r     <= cnt_r - 1'b1;
            src_r     <= src_r + 1'b1;
            rd_pend_r <= 1'b1;
          end else if (!rd_pend_r) begin
            if (mrem_r != '0) begin
              cnt_r  <= mrem_r;
              mrem_r <= '0;
              src_r  <= '0;
            end
          end
        end
        lz77se_pkg::BK_ORD: begin
          if (rd_pend_r) begin
            wrd_r <= rdat_r;
          end else begin
            rd_pend_r <= 1'b1;
          end
        end
        lz77se_pkg::BK_DONE: begin
          if (!ov_r || !out_stall) begin
            ostat_r <= wstat_r;
            oseq_r  <= wseq_r;
            ord_r   <= wrd_r;
          end
        end
        default: ;
      endcase
    end
  end

  // Memory ports: registered reads, writes from registered data.
  logic          phase_lit;
  logic [PW-1:0] rd_src;
  assign phase_lit = (mrem_r == '1);
  assign rd_src    = src_r;

  always_ff @(posedge clk) begin
    if (st_r == lz77se_pkg::BK_ORD) begin
      rdat_r <= omem[addr_w[OAW-1:0]];
    end else if (st_r == lz77se_pkg::BK_DICT) begin
      rdat_r <= dmem[rd_src[DAW-1:0]];
    end else if (phase_lit) begin
      rdat_r <= lmem[rd_src[LAW-1:0]];
    end else if (om_we && rd_src[OAW-1:0] == dst_r[OAW-1:0]) begin
      rdat_r <= rdat_r;
    end else begin
      rdat_r <= omem[rd_src[OAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (om_we) begin
      omem[dst_r[OAW-1:0]] <= rdat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (lm_we) begin
      lmem[lcnt_r[LAW-1:0]] <= cmd_r.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dmem[addr_w[DAW-1:0]] <= cmd_r.data_byte;
    end
  end

  a_wpos_cap: assert property (@(posedge clk) disable iff (!rst_n)
    wpos_r <= PW'(OUT_DEPTH)) else $error("write position past output depth");
  a_lrp_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    lrp_r <= lcnt_r) else $error("literal pointer past literal count");
  a_ov_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(st_r) == lz77se_pkg::BK_DONE) else $error("result outside done");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> st_r == lz77se_pkg::BK_LRD) else $error("command lost");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status)
      && $stable(out_seq_length) && $stable(out_read_data)))
    else $error("stalled result changed");

endmodule

// ----- rtl/lz77_sequence_executor.sv -----
// Top level: LZ77 sequence executor with external dictionary.
// Commands enter a two-entry queue and a back end executes one at a time.
// An executed sequence copies its literal and match bytes into the output
// memory one byte per cycle.
module lz77_sequence_executor #(
  parameter int unsigned OUT_DEPTH  = lz77se_pkg::OutDepthDef,
  parameter int unsigned LIT_DEPTH  = lz77se_pkg::LitDepthDef,
  parameter int unsigned DICT_DEPTH = lz77se_pkg::DictDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_address,
  input  logic [16:0] in_lit_length,
  input  logic [16:0] in_match_length,
  input  logic [17:0] in_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [17:0] out_seq_length,
  output logic [7:0]  out_read_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data
);

  logic             q_valid, q_pop;
  lz77se_pkg::cmd_t q_cmd;
  logic [16:0]      cap_r, dlen_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= lz77se_pkg::CapReset;
      dlen_r <= lz77se_pkg::DlenReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (lz77se_pkg::cfg_idx_t'(cfg_index))
        lz77se_pkg::CFG_CAP:  cap_r  <= cfg_data;
        lz77se_pkg::CFG_DLEN: dlen_r <= cfg_data;
        default: ;
      endcase
    end
  end

  lz77se_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_data_byte, .in_address,
    .in_lit_length, .in_match_length, .in_offset,
    .q_valid, .q_cmd, .q_pop
  );

  lz77se_back #(
    .OUT_DEPTH(OUT_DEPTH), .LIT_DEPTH(LIT_DEPTH), .DICT_DEPTH(DICT_DEPTH)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_pop,
    .cap_cfg(cap_r), .dlen_cfg(dlen_r),
    .out_valid, .out_stall, .out_status, .out_seq_length, .out_read_data
  );

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the LZ77 sequence executor: directed and random command beats checked against a predictor.
`timescale 1ns / 100ps

module tb_top;

  localparam int Depth = 65536;
  localparam int DictTail = 64;
  localparam int FullCap = 65536;
  localparam logic [2:0] ActUnknown = 3'd5;

  typedef struct {
    lz77se_pkg::status_t status;
    logic [17:0]         seq_length;
    logic [7:0]          read_data;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_action = '0;
  logic [7:0]  in_data_byte = '0;
  logic [15:0] in_address = '0;
  logic [16:0] in_lit_length = '0;
  logic [16:0] in_match_length = '0;
  logic [17:0] in_offset = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [17:0] out_seq_length;
  logic [7:0]  out_read_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [16:0] cfg_data = '0;

  logic [7:0] out_img [Depth];
  logic [7:0] lit_img [Depth];
  logic [7:0] dict_img [Depth];
  int wr_pos = 0;
  int lit_rd = 0;
  int lit_cnt = 0;
  int cap_reg = 65536;
  int dlen_reg = 0;
  int out_hi = 0;
  int errors = 0;
  int hold_left = 0;
  bit calm = 1'b0;
  result_t pending_q[$];

  lz77_sequence_executor DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_data_byte(in_data_byte), .in_address(in_address), .in_lit_length(in_lit_length),
    .in_match_length(in_match_length), .in_offset(in_offset),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_seq_length(out_seq_length), .out_read_data(out_read_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    #6000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int dict_span();
    return (dlen_reg > Depth) ? Depth : dlen_reg;
  endfunction

  function automatic result_t run_command(logic [2:0] act, logic [7:0] d, logic [15:0] a,
                                          logic [16:0] ll, logic [16:0] ml, logic [17:0] of);
    result_t r;
    int cap, dl, lend, mend, back, first, dst, k;
    r.status = lz77se_pkg::ST_OK;
    r.seq_length = '0;
    r.read_data = '0;
    cap = (cap_reg > Depth) ? Depth : cap_reg;
    dl = dict_span();
    unique case (act)
      lz77se_pkg::ACT_LIT: if (lit_cnt < Depth) begin
        lit_img[lit_cnt] = d;
        lit_cnt++;
      end
      lz77se_pkg::ACT_DICT: dict_img[a] = d;
      lz77se_pkg::ACT_READ: r.read_data = out_img[a];
      lz77se_pkg::ACT_CLEAR: begin
        lit_cnt = 0;
        lit_rd = 0;
      end
      lz77se_pkg::ACT_EXEC: begin
        lend = wr_pos + int'(ll);
        mend = lend + int'(ml);
        if (mend > cap) r.status = lz77se_pkg::ST_SMALL;
        else if (lit_rd + int'(ll) > lit_cnt) r.status = lz77se_pkg::ST_CORRUPT;
        else begin
          for (k = 0; k < int'(ll); k++) out_img[wr_pos + k] = lit_img[lit_rd + k];
          lit_rd += int'(ll);
          if (lend > out_hi) out_hi = lend;
          if (of == 0 || int'(of) > lend + dl) r.status = lz77se_pkg::ST_CORRUPT;
          else begin
            dst = lend;
            if (int'(of) > lend) begin
              back = int'(of) - lend;
              first = (int'(ml) < back) ? int'(ml) : back;
              for (k = 0; k < first; k++) out_img[dst + k] = dict_img[Depth - back + k];
              dst += first;
              for (k = 0; dst < mend; k++, dst++) out_img[dst] = out_img[k];
            end else begin
              for (k = lend - int'(of); dst < mend; k++, dst++) out_img[dst] = out_img[k];
            end
            wr_pos = mend;
            if (mend > out_hi) out_hi = mend;
            r.seq_length = ll + ml;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // drop offsets that would reach dictionary entries never written
  function automatic logic [17:0] safe_offset(logic [16:0] ll, logic [17:0] of);
    int lend;
    lend = wr_pos + int'(ll);
    if (int'(of) > lend && int'(of) <= lend + dict_span() && int'(of) - lend > DictTail)
      return '0;
    return of;
  endfunction

  task automatic send_beat(logic [2:0] act, logic [7:0] d, logic [15:0] a,
                           logic [16:0] ll, logic [16:0] ml, logic [17:0] of);
    if (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_data_byte <= d;
    in_address <= a;
    in_lit_length <= ll;
    in_match_length <= ml;
    in_offset <= of;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(run_command(act, d, a, ll, ml, of));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(lz77se_pkg::cfg_idx_t idx, logic [16:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == lz77se_pkg::CFG_CAP) cap_reg = val;
    else dlen_reg = val;
    @(posedge clk);
  endtask

  task automatic exec_seq(int ll, int ml, int of);
    send_beat(lz77se_pkg::ACT_EXEC, 8'd0, 16'd0, ll[16:0], ml[16:0], of[17:0]);
  endtask

  task automatic read_out(int a);
    send_beat(lz77se_pkg::ACT_READ, 8'd0, a[15:0], '0, '0, '0);
  endtask

  // check each result beat against the oldest prediction
  initial begin
    result_t e;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result beat status %0d", $time, out_status);
          errors++;
        end else begin
          e = pending_q.pop_front();
          if (out_status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
            errors++;
          end
          if (out_seq_length !== e.seq_length) begin
            $display("%0t: seq_length expected %0d actual %0d", $time, e.seq_length,
                     out_seq_length);
            errors++;
          end
          if (out_read_data !== e.read_data) begin
            $display("%0t: read_data expected %0h actual %0h", $time, e.read_data,
                     out_read_data);
            errors++;
          end
        end
      end
    end
  end

  // receiver hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 24);
      end
    end
  end

  task automatic test_literals_and_clear();
    send_beat(lz77se_pkg::ACT_LIT, 8'h00, '0, '0, '0, '0);
    send_beat(lz77se_pkg::ACT_LIT, 8'hFF, '0, '0, '0, '0);
    send_beat(lz77se_pkg::ACT_CLEAR, '0, '0, '0, '0, '0);
    send_beat(ActUnknown, 8'hFF, 16'hFFFF, '1, '1, '1);
    send_beat(ActUnknown + 3'd1, 8'h00, '0, '0, '0, '0);
    send_beat(ActUnknown + 3'd2, 8'hA5, 16'h1234, 17'h10000, 17'h1, 18'h20000);
  endtask

  task automatic test_dictionary();
    int k;
    send_beat(lz77se_pkg::ACT_DICT, 8'h00, 16'd0, '0, '0, '0);
    for (k = Depth - DictTail; k < Depth; k++)
      send_beat(lz77se_pkg::ACT_DICT, (k == Depth - 1) ? 8'hFF : 8'($urandom), k[15:0],
                '0, '0, '0);
  endtask

  task automatic test_sequences();
    int k;
    for (k = 0; k < 16; k++) send_beat(lz77se_pkg::ACT_LIT, 8'($urandom), '0, '0, '0, '0);
    exec_seq(4, 0, 1);
    exec_seq(4, 8, 1);
    exec_seq(0, 3, 0);
    exec_seq(100, 0, 1);
    cfg_write(lz77se_pkg::CFG_DLEN, 17'd64);
    exec_seq(0, 10, wr_pos + 5);
    exec_seq(2, 3, wr_pos + 2 + 65);
    for (k = 0; k < 4; k++) read_out($urandom_range(out_hi - 1));
    read_out(0);
  endtask

  task automatic test_capacity();
    cfg_write(lz77se_pkg::CFG_CAP, 17'd0);
    exec_seq(0, 0, 1);
    exec_seq(0, 1, 1);
    cfg_write(lz77se_pkg::CFG_CAP, 17'(wr_pos + 5));
    exec_seq(0, 5, 1);
    exec_seq(0, 1, 1);
    cfg_write(lz77se_pkg::CFG_CAP, 17'h1FFFF);
  endtask

  task automatic rand_beat();
    int r, ll, ml, lend, dlim, k;
    logic [17:0] of;
    logic [2:0] act;
    logic [15:0] a;
    r = $urandom_range(99);
    if (r < 20 || (r >= 28 && r < 35 && out_hi == 0)) begin
      send_beat(lz77se_pkg::ACT_LIT, 8'($urandom), 16'($urandom), '0, '0, '0);
    end else if (r < 28) begin
      send_beat(lz77se_pkg::ACT_DICT, 8'($urandom), 16'($urandom), '0, '0, '0);
    end else if (r < 35) begin
      read_out($urandom_range(out_hi - 1));
    end else if (r < 38) begin
      send_beat(lz77se_pkg::ACT_CLEAR, 8'($urandom), 16'($urandom), '0, '0, '0);
    end else if (r < 88) begin
      k = lit_cnt - lit_rd;
      ll = $urandom_range((k < 8) ? k : 8);
      ml = $urandom_range(24);
      lend = wr_pos + ll;
      dlim = (dict_span() < DictTail) ? dict_span() : DictTail;
      k = $urandom_range(9);
      if (k < 6 && lend > 0) of = 18'($urandom_range(1, (lend < 64) ? lend : 64));
      else if (k < 8 && dlim > 0) of = 18'(lend + $urandom_range(1, dlim));
      else if ($urandom_range(1) && lend + dict_span() + 1 < 262144)
        of = 18'(lend + dict_span() + 1 + $urandom_range(3));
      else of = '0;
      exec_seq(ll, ml, of);
    end else begin
      act = 3'($urandom);
      a = 16'($urandom);
      if (act == lz77se_pkg::ACT_READ)
        a = (out_hi == 0) ? 16'd0 : 16'($urandom_range(out_hi - 1));
      if (act == lz77se_pkg::ACT_READ && out_hi == 0) act = lz77se_pkg::ACT_CLEAR;
      of = 18'($urandom);
      ll = $urandom_range(131071);
      of = safe_offset(ll[16:0], of);
      send_beat(act, 8'($urandom), a, ll[16:0], 17'($urandom), of);
    end
  endtask

  task automatic test_backpressure();
    int k;
    drain();
    hold_left = 300;
    for (k = 0; k < 30; k++) rand_beat();
    drain();
  endtask

  task automatic test_random();
    int k;
    for (k = 0; k < 260; k++) begin
      calm = (k >= 100 && k < 170);
      rand_beat();
    end
    calm = 1'b0;
    drain();
  endtask

  task automatic test_fill();
    cfg_write(lz77se_pkg::CFG_DLEN, 17'd65536);
    cfg_write(lz77se_pkg::CFG_CAP, 17'd65536);
    exec_seq(0, 4, wr_pos + 10);
    exec_seq(0, FullCap - wr_pos, 1);
    exec_seq(0, 1, 1);
    exec_seq(0, 0, 1);
    read_out(Depth - 1);
    read_out(Depth / 2);
    read_out($urandom_range(Depth - 1));
    cfg_write(lz77se_pkg::CFG_DLEN, 17'h1FFFF);
    exec_seq(0, 0, 1);
    cfg_write(lz77se_pkg::CFG_DLEN, 17'd0);
    exec_seq(0, 0, 1);
    read_out(Depth - 2);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_literals_and_clear();
    test_dictionary();
    test_sequences();
    test_capacity();
    test_backpressure();
    test_random();
    test_fill();
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/lz77se_pkg.sv
rtl/lz77se_front.sv
rtl/lz77se_back.sv
rtl/lz77_sequence_executor.sv
tb/sv/tb_top.sv
